// ----- rtl/core/odo_pkg.sv -----
// Shared constants, types and the arctangent table of the odometry block.
package odo_pkg;

  localparam int CNT_W        = 32;
  localparam int REG_W        = 24;
  localparam int MUL_W        = 34;
  localparam int MULP_W       = 2 * MUL_W;
  localparam int CORD_W       = 34;
  localparam int CORDIC_STEPS = 30;
  localparam int STEP_W       = 5;
  localparam int DIV_STEPS    = 32;

  localparam logic [REG_W-1:0]  DPT_RESET   = 24'd2464727;
  localparam logic [REG_W-1:0]  INV_RESET   = 24'd304534;
  localparam logic [CORD_W-1:0] CORDIC_GAIN = 34'd652032874;
  localparam logic [29:0]       RAD_TO_BIN  = 30'd683565276;
  localparam logic [19:0]       US_PER_S    = 20'd1000000;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

  typedef enum logic {
    REG_DIST_PER_TICK = 1'b0,
    REG_INV_TRACK     = 1'b1
  } reg_idx_t;

  // arctan(2^-i) as binary angle, 2^32 = one turn
  function automatic logic [29:0] atan_bin(input logic [STEP_W-1:0] idx);
    logic [29:0] v;
    case (idx)
      5'd0:  v = 30'd536870912;
      5'd1:  v = 30'd316933406;
      5'd2:  v = 30'd167458907;
      5'd3:  v = 30'd85004756;
      5'd4:  v = 30'd42667331;
      5'd5:  v = 30'd21354465;
      5'd6:  v = 30'd10679838;
      5'd7:  v = 30'd5340245;
      5'd8:  v = 30'd2670163;
      5'd9:  v = 30'd1335087;
      5'd10: v = 30'd667544;
      5'd11: v = 30'd333772;
      5'd12: v = 30'd166886;
      5'd13: v = 30'd83443;
      5'd14: v = 30'd41722;
      5'd15: v = 30'd20861;
      5'd16: v = 30'd10430;
      5'd17: v = 30'd5215;
      5'd18: v = 30'd2608;
      5'd19: v = 30'd1304;
      5'd20: v = 30'd652;
      5'd21: v = 30'd326;
      5'd22: v = 30'd163;
      5'd23: v = 30'd81;
      5'd24: v = 30'd41;
      5'd25: v = 30'd20;
      5'd26: v = 30'd10;
      5'd27: v = 30'd5;
      5'd28: v = 30'd3;
      5'd29: v = 30'd1;
      default: v = 30'd0;
    endcase
    return v;
  endfunction

endpackage

// ----- rtl/core/diff_drive_odometry_unit.sv -----
// Top level of the differential-drive wheel odometry block.
//
// Input channel (in_valid / in_stall): one word carries the raw right and
// left encoder counts and the elapsed time in microseconds. A word is taken
// when in_valid is high and in_stall is low. in_stall stays high while a
// word is being worked on.
// Output channel (out_valid / out_stall): one result word per input word:
// pose, half-angle quaternion and the two velocities. The result sits in an
// output register; a stalled receiver only holds the block once the next
// result is finished and the register is still full.
// The block takes no new word until its result has been loaded into the
// output register. The two CORDIC passes (step heading, half heading)
// run one after the other, followed by the two 32-step divisions for the
// velocities; products go through one shared 34x34 multiplier, one
// product per cycle.
// Configuration: APB writes at byte 0 (distance_per_tick) and byte 4
// (inverse_track); the user writes only while no word is in flight, which the block itself does not enforce.
// Reset: pose, stored counts and output valid clear, registers take their
// default values.
module diff_drive_odometry_unit (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic signed [31:0]         in_right_count,
  input  logic signed [31:0]         in_left_count,
  input  logic [31:0]                in_elapsed_us,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic signed [31:0]         out_pos_x,
  output logic signed [31:0]         out_pos_y,
  output logic [31:0]                out_heading,
  output logic signed [15:0]         out_quat_z,
  output logic signed [15:0]         out_quat_w,
  output logic signed [31:0]         out_linear_velocity,
  output logic signed [31:0]         out_angular_velocity,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [2:0]                 paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);
  import odo_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_M1, S_M2, S_M3, S_M4, S_M5, S_M6, S_M7, S_M8,
    S_C1S, S_C1, S_M9, S_M10, S_M11, S_M12, S_M13, S_C2S, S_C2,
    S_V0, S_V1, S_V2, S_V3, S_VW, S_OUT
  } state_t;

  state_t              state_r;
  logic [REG_W-1:0]    dpt_r, inv_r;
  logic [CNT_W-1:0]    last_right_r, last_left_r;
  logic [CNT_W-1:0]    acc_x_r, acc_y_r, acc_h_r;
  logic [CNT_W:0]      sum_r, dif_r;
  logic [CNT_W-1:0]    t_r;
  logic [40:0]         d_r;
  logic [32:0]         sh_r;
  logic [24:0]         bsh_r;
  logic [49:0]         dth_r;
  logic [47:0]         lk_r;
  logic [CNT_W-1:0]    dbin_r;
  logic [63:0]         tmp_r;
  logic [43:0]         mag_r;
  logic                vsel_r, vneg_r, vbig_r;
  logic [15:0]         qz_r, qw_r;
  logic [CNT_W-1:0]    lin_r;
  logic                out_valid_r;
  logic [CNT_W-1:0]    opx_r, opy_r, oph_r, olin_r, oang_r;
  logic [15:0]         oqz_r, oqw_r;

  logic                      in_acc, cfg_wr, out_load;
  logic [CNT_W-1:0]          dr_c, dl_c;
  logic signed [MUL_W-1:0]   mul_a, mul_b;
  logic signed [MULP_W-1:0]  mul_p;
  logic                      cor_start, div_start;
  logic [CNT_W-1:0]          cor_angle;
  unit_stat_t                cor_stat, div_stat;
  logic signed [CORD_W-1:0]  cor_cos, cor_sin;
  logic [CNT_W-1:0]          div_quo;
  logic                      div_ovf;
  logic [MULP_W-1:0]         dsum_c;
  logic [48:0]               b_c;
  logic [57:0]               a_c;
  logic [47:0]               h48_c;
  logic [61:0]               pose_c;
  logic [49:0]               v50_c, mag50_c;
  logic [63:0]               num_c;
  logic [CNT_W:0]            q33_c, qn_c;
  logic [CNT_W-1:0]          rate_c;

  // round Q2.30 to Q1.14 and clamp to plus or minus one
  function automatic logic [15:0] to_q14(input logic signed [CORD_W-1:0] v);
    logic signed [CORD_W:0] s;
    logic signed [18:0]     r;
    logic [15:0]            o;
    s = {v[CORD_W-1], v} + 35'sd32768;
    r = s[CORD_W:16];
    if (r > 19'sd16384) begin
      o = 16'h4000;
    end else if (r < -19'sd16384) begin
      o = 16'hC000;
    end else begin
      o = r[15:0];
    end
    return o;
  endfunction

  assign in_acc   = in_valid && !in_stall;
  assign in_stall = (state_r != S_IDLE);
  assign cfg_wr   = psel && penable && pwrite && pready;
  assign pready   = 1'b1;
  assign dr_c     = in_right_count - last_right_r;
  assign dl_c     = in_left_count - last_left_r;
  assign out_load = (state_r == S_OUT) && (!out_valid_r || !out_stall);

  always_comb begin
    case (reg_idx_t'(paddr[2]))
      REG_DIST_PER_TICK: prdata = {8'b0, dpt_r};
      REG_INV_TRACK:     prdata = {8'b0, inv_r};
      default:           prdata = '0;
    endcase
  end

  // operand select for the shared multiplier, one product per state that drives it
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      S_M1: begin
        mul_a = {sum_r[CNT_W], sum_r};
        mul_b = {10'b0, dpt_r};
      end
      S_M2: begin
        mul_a = {dif_r[CNT_W], dif_r};
        mul_b = {10'b0, dpt_r};
      end
      S_M3: begin
        mul_a = {10'b0, mul_p[23:0]};
        mul_b = {10'b0, inv_r};
      end
      S_M4: begin
        mul_a = {sh_r[32], sh_r};
        mul_b = {10'b0, inv_r};
      end
      S_M6: begin
        mul_a = {10'b0, dth_r[23:0]};
        mul_b = {4'b0, RAD_TO_BIN};
      end
      S_M7: begin
        mul_a = {10'b0, dth_r[47:24]};
        mul_b = {4'b0, RAD_TO_BIN};
      end
      S_M9: begin
        mul_a = {10'b0, d_r[23:0]};
        mul_b = cor_cos;
      end
      S_M10: begin
        mul_a = {{17{d_r[40]}}, d_r[40:24]};
        mul_b = cor_cos;
      end
      S_M11: begin
        mul_a = {10'b0, d_r[23:0]};
        mul_b = cor_sin;
      end
      S_M12: begin
        mul_a = {{17{d_r[40]}}, d_r[40:24]};
        mul_b = cor_sin;
      end
      S_V1: begin
        mul_a = {10'b0, mag_r[23:0]};
        mul_b = {14'b0, US_PER_S};
      end
      S_V2: begin
        mul_a = {14'b0, mag_r[43:24]};
        mul_b = {14'b0, US_PER_S};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    dsum_c  = mul_p + 68'sd65536;
    b_c     = mul_p[48:0] + 49'h0_8000_0000;
    a_c     = mul_p[57:0] + {33'b0, bsh_r};
    h48_c   = lk_r + {mul_p[23:0], 24'b0} + 48'd32768;
    pose_c  = tmp_r[61:0] + {mul_p[37:0], 24'b0} + 62'h2000_0000;
    v50_c   = vsel_r ? dth_r : {{9{d_r[40]}}, d_r};
    mag50_c = v50_c[49] ? (50'd0 - v50_c) : v50_c;
    num_c   = tmp_r + {mul_p[39:0], 24'b0} + {33'b0, t_r[CNT_W-1:1]};
    q33_c   = (vbig_r || div_ovf) ? 33'h1_0000_0000 : {1'b0, div_quo};
    qn_c    = (q33_c > 33'h0_8000_0000) ? 33'h0_8000_0000 : q33_c;
    if (t_r == '0) begin
      rate_c = '0;
    end else if (vneg_r) begin
      rate_c = 32'd0 - qn_c[CNT_W-1:0];
    end else begin
      rate_c = (q33_c > 33'h0_7FFF_FFFF) ? 32'h7FFF_FFFF : q33_c[CNT_W-1:0];
    end
  end

  assign cor_start = (state_r == S_C1S) || (state_r == S_C2S);
  assign cor_angle = (state_r == S_C1S) ? (acc_h_r - dbin_r) : {1'b0, acc_h_r[CNT_W-1:1]};
  assign div_start = (state_r == S_V3);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      dpt_r        <= DPT_RESET;
      inv_r        <= INV_RESET;
      last_right_r <= '0;
      last_left_r  <= '0;
      acc_x_r      <= '0;
      acc_y_r      <= '0;
      acc_h_r      <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_wr) begin
        case (reg_idx_t'(paddr[2]))
          REG_DIST_PER_TICK: dpt_r <= pwdata[REG_W-1:0];
          REG_INV_TRACK:     inv_r <= pwdata[REG_W-1:0];
          default:           dpt_r <= dpt_r;
        endcase
      end
      // raise on a new result, drop once the receiver takes it
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            sum_r        <= {dr_c[CNT_W-1], dr_c} + {dl_c[CNT_W-1], dl_c};
            dif_r        <= {dr_c[CNT_W-1], dr_c} - {dl_c[CNT_W-1], dl_c};
            t_r          <= in_elapsed_us;
            last_right_r <= in_right_count;
            last_left_r  <= in_left_count;
            state_r      <= S_M1;
          end
        end
        S_M1: state_r <= S_M2;
        S_M2: begin
          d_r     <= dsum_c[57:17];
          state_r <= S_M3;
        end
        S_M3: begin
          sh_r    <= mul_p[56:24];
          state_r <= S_M4;
        end
        S_M4: begin
          bsh_r   <= b_c[48:24];
          state_r <= S_M5;
        end
        S_M5: begin
          dth_r   <= a_c[57:8];
          state_r <= S_M6;
        end
        S_M6: state_r <= S_M7;
        S_M7: begin
          lk_r    <= mul_p[47:0];
          state_r <= S_M8;
        end
        S_M8: begin
          dbin_r  <= h48_c[47:16];
          state_r <= S_C1S;
        end
        S_C1S: state_r <= S_C1;
        S_C1: begin
          if (cor_stat.done) begin
            state_r <= S_M9;
          end
        end
        S_M9: state_r <= S_M10;
        S_M10: begin
          tmp_r   <= mul_p[63:0];
          state_r <= S_M11;
        end
        S_M11: begin
          acc_x_r <= acc_x_r + pose_c[61:30];
          state_r <= S_M12;
        end
        S_M12: begin
          tmp_r   <= mul_p[63:0];
          state_r <= S_M13;
        end
        S_M13: begin
          acc_y_r <= acc_y_r + pose_c[61:30];
          acc_h_r <= acc_h_r + dbin_r;
          state_r <= S_C2S;
        end
        S_C2S: state_r <= S_C2;
        S_C2: begin
          if (cor_stat.done) begin
            qz_r    <= to_q14(cor_sin);
            qw_r    <= to_q14(cor_cos);
            vsel_r  <= 1'b0;
            state_r <= S_V0;
          end
        end
        S_V0: begin
          vneg_r  <= v50_c[49];
          vbig_r  <= |mag50_c[49:44];
          mag_r   <= mag50_c[43:0];
          state_r <= S_V1;
        end
        S_V1: state_r <= S_V2;
        S_V2: begin
          tmp_r   <= mul_p[63:0];
          state_r <= S_V3;
        end
        S_V3: state_r <= S_VW;
        S_VW: begin
          if (div_stat.done) begin
            if (!vsel_r) begin
              lin_r   <= rate_c;
              vsel_r  <= 1'b1;
              state_r <= S_V0;
            end else begin
              tmp_r   <= {32'b0, rate_c};
              state_r <= S_OUT;
            end
          end
        end
        S_OUT: begin
          // hold until the output register is free
          if (out_load) begin
            opx_r       <= acc_x_r;
            opy_r       <= acc_y_r;
            oph_r       <= acc_h_r;
            oqz_r       <= qz_r;
            oqw_r       <= qw_r;
            olin_r      <= lin_r;
            oang_r      <= tmp_r[CNT_W-1:0];
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  odo_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p_r (mul_p)
  );

  odo_cordic u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cor_start),
    .angle (cor_angle),
    .stat  (cor_stat),
    .cos_q (cor_cos),
    .sin_q (cor_sin)
  );

  odo_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (num_c),
    .den   (t_r),
    .stat  (div_stat),
    .quo   (div_quo),
    .ovf   (div_ovf)
  );

  assign out_valid            = out_valid_r;
  assign out_pos_x            = opx_r;
  assign out_pos_y            = opy_r;
  assign out_heading          = oph_r;
  assign out_quat_z           = oqz_r;
  assign out_quat_w           = oqw_r;
  assign out_linear_velocity  = olin_r;
  assign out_angular_velocity = oang_r;

  a_stall_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> in_stall)
    else $error("input taken while a word is in flight");

  a_out_from_final: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(state_r == S_OUT))
    else $error("result raised outside the output step");

  a_cordic_idle_start: assert property (@(posedge clk) disable iff (!rst_n)
    cor_start |-> !cor_stat.busy)
    else $error("CORDIC restarted while busy");

  a_div_idle_start: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> !div_stat.busy)
    else $error("divider restarted while busy");

  a_cordic_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
    cor_stat.done |-> (state_r == S_C1 || state_r == S_C2))
    else $error("CORDIC finished with no step waiting for it");

endmodule

// ----- rtl/core/odo_mul.sv -----
// Shared signed multiplier with registered product.
module odo_mul (
  input  logic                               clk,
  input  logic signed [odo_pkg::MUL_W-1:0]   a,
  input  logic signed [odo_pkg::MUL_W-1:0]   b,
  output logic signed [odo_pkg::MULP_W-1:0]  p_r
);
  import odo_pkg::*;

  always_ff @(posedge clk) begin
    p_r <= a * b;
  end

endmodule

// ----- rtl/core/odo_cordic.sv -----
// Iterative rotation-mode CORDIC giving cosine and sine of a binary angle.
module odo_cordic (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  input  logic [odo_pkg::CNT_W-1:0]          angle,
  output odo_pkg::unit_stat_t                stat,
  output logic signed [odo_pkg::CORD_W-1:0]  cos_q,
  output logic signed [odo_pkg::CORD_W-1:0]  sin_q
);
  import odo_pkg::*;

  typedef enum logic {C_IDLE, C_RUN} state_t;

  localparam logic signed [CORD_W-1:0] QUARTER = 34'sh040000000;
  localparam logic signed [CORD_W-1:0] HALF    = 34'sh080000000;
  localparam logic [STEP_W-1:0]        LAST    = STEP_W'(CORDIC_STEPS - 1);

  state_t                    state_r;
  logic [STEP_W-1:0]         cnt_r;
  logic signed [CORD_W-1:0]  x_r, y_r, z_r, cos_r, sin_r;
  logic                      flip_r, done_r;

  logic signed [CORD_W-1:0]  z_ext, z_init, dx, dy, at;
  logic signed [CORD_W-1:0]  x_nxt, y_nxt, z_nxt;
  logic                      flip_init;

  always_comb begin
    z_ext     = {{(CORD_W-CNT_W){angle[CNT_W-1]}}, angle};
    z_init    = z_ext;
    flip_init = 1'b0;
    // fold into the right half plane, negate at the end
    if (z_ext > QUARTER) begin
      z_init    = z_ext - HALF;
      flip_init = 1'b1;
    end else if (z_ext < -QUARTER) begin
      z_init    = z_ext + HALF;
      flip_init = 1'b1;
    end
    dx = y_r >>> cnt_r;
    dy = x_r >>> cnt_r;
    at = {{(CORD_W-30){1'b0}}, atan_bin(cnt_r)};
    if (!z_r[CORD_W-1]) begin
      x_nxt = x_r - dx;
      y_nxt = y_r + dy;
      z_nxt = z_r - at;
    end else begin
      x_nxt = x_r + dx;
      y_nxt = y_r - dy;
      z_nxt = z_r + at;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= C_IDLE;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      case (state_r)
        C_IDLE: begin
          if (start) begin
            x_r     <= CORDIC_GAIN;
            y_r     <= '0;
            z_r     <= z_init;
            flip_r  <= flip_init;
            cnt_r   <= '0;
            state_r <= C_RUN;
          end
        end
        C_RUN: begin
          x_r   <= x_nxt;
          y_r   <= y_nxt;
          z_r   <= z_nxt;
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == LAST) begin
            cos_r   <= flip_r ? -x_nxt : x_nxt;
            sin_r   <= flip_r ? -y_nxt : y_nxt;
            done_r  <= 1'b1;
            state_r <= C_IDLE;
          end
        end
        default: state_r <= C_IDLE;
      endcase
    end
  end

  assign stat.busy = (state_r == C_RUN);
  assign stat.done = done_r;
  assign cos_q     = cos_r;
  assign sin_q     = sin_r;

endmodule

// ----- rtl/core/odo_div.sv -----
// Restoring divider, one quotient bit per cycle, 64 by 32 with overflow flag.
module odo_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [2*odo_pkg::CNT_W-1:0] num,
  input  logic [odo_pkg::CNT_W-1:0]   den,
  output odo_pkg::unit_stat_t         stat,
  output logic [odo_pkg::CNT_W-1:0]   quo,
  output logic                        ovf
);
  import odo_pkg::*;

  typedef enum logic {D_IDLE, D_RUN} state_t;

  localparam logic [STEP_W-1:0] LAST = STEP_W'(DIV_STEPS - 1);

  state_t             state_r;
  logic [STEP_W-1:0]  cnt_r;
  logic [CNT_W-1:0]   rem_r, low_r, den_r;
  logic               ovf_r, done_r;

  logic [CNT_W:0]     trial, diff;
  logic               ge;

  always_comb begin
    trial = {rem_r, low_r[CNT_W-1]};
    diff  = trial - {1'b0, den_r};
    ge    = (trial >= {1'b0, den_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= D_IDLE;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      case (state_r)
        D_IDLE: begin
          if (start) begin
            rem_r   <= num[2*CNT_W-1:CNT_W];
            low_r   <= num[CNT_W-1:0];
            den_r   <= den;
            ovf_r   <= (num[2*CNT_W-1:CNT_W] >= den);
            cnt_r   <= '0;
            state_r <= D_RUN;
          end
        end
        D_RUN: begin
          rem_r <= ge ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
          low_r <= {low_r[CNT_W-2:0], ge};
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == LAST) begin
            done_r  <= 1'b1;
            state_r <= D_IDLE;
          end
        end
        default: state_r <= D_IDLE;
      endcase
    end
  end

  assign stat.busy = (state_r == D_RUN);
  assign stat.done = done_r;
  assign quo       = low_r;
  assign ovf       = ovf_r;

endmodule

// ----- tb/odo_checker.sv -----
// Result predictor and scoreboard for the odometry block.
module odo_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic signed [31:0] in_right_count,
  input  logic signed [31:0] in_left_count,
  input  logic [31:0]        in_elapsed_us,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic signed [31:0] out_pos_x,
  input  logic signed [31:0] out_pos_y,
  input  logic [31:0]        out_heading,
  input  logic signed [15:0] out_quat_z,
  input  logic signed [15:0] out_quat_w,
  input  logic signed [31:0] out_linear_velocity,
  input  logic signed [31:0] out_angular_velocity,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  input  logic               pready,
  output int                 fail_count,
  output int                 pending
);
  import odo_pkg::*;

  typedef struct {
    logic [31:0] pos_x;
    logic [31:0] pos_y;
    logic [31:0] heading;
    logic [15:0] quat_z;
    logic [15:0] quat_w;
    logic [31:0] lin_vel;
    logic [31:0] ang_vel;
  } pose_word_t;

  localparam longint ATAN_TBL [0:29] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
    41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
    10, 5, 3, 1};

  pose_word_t  pose_q[$];
  logic [23:0] dist_per_tick, inv_track;
  logic [31:0] prev_right, prev_left, pose_x, pose_y, pose_hdg;

  // CORDIC sine/cosine in Q2.30, angle folded into +-90 degrees
  function automatic void sincos_q30(input logic [31:0] ang, output longint c,
                                     output longint s);
    longint z, x, y, dx, dy;
    bit flip;
    z = longint'(signed'(ang));
    x = CORDIC_GAIN;
    y = 0;
    flip = 0;
    if (z > (64'sd1 <<< 30)) begin
      z -= (64'sd1 <<< 31);
      flip = 1;
    end else if (z < -(64'sd1 <<< 30)) begin
      z += (64'sd1 <<< 31);
      flip = 1;
    end
    for (int i = 0; i < 30; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= ATAN_TBL[i];
      end else begin
        x += dx; y -= dy; z += ATAN_TBL[i];
      end
    end
    if (flip) begin
      x = -x; y = -y;
    end
    c = x;
    s = y;
  endfunction

  function automatic logic [15:0] round_q14(input longint v);
    longint r;
    r = (v + 32768) >>> 16;
    if (r > 16384) r = 16384;
    if (r < -16384) r = -16384;
    return r[15:0];
  endfunction

  // per-second rate in Q16.16, rounded on the magnitude, saturated
  function automatic logic [31:0] per_second(input longint v, input logic [31:0] t);
    bit neg;
    longint unsigned m, q;
    neg = v < 0;
    m = neg ? longint'(-v) : longint'(v);
    if (t == 0) return 32'd0;
    if (m >= (64'd1 << 44)) q = 64'd1 << 32;
    else q = (m * 64'd1000000 + t / 2) / t;
    if (neg) begin
      if (q > 64'h8000_0000) q = 64'h8000_0000;
      q = -q;
      return q[31:0];
    end
    if (q > 64'h7FFF_FFFF) q = 64'h7FFF_FFFF;
    return q[31:0];
  endfunction

  // advance the pose by one word and return the expected result
  function automatic pose_word_t advance_pose(input logic [31:0] rc, input logic [31:0] lc,
                                              input logic [31:0] t);
    pose_word_t w;
    longint dr, dl, d, s, dth, cs, sn;
    logic signed [127:0] wide;
    longint unsigned p;
    logic [31:0] dbin, half;
    dr = longint'(signed'(rc - prev_right));
    dl = longint'(signed'(lc - prev_left));
    prev_right = rc;
    prev_left = lc;
    d = ((dr + dl) * longint'(dist_per_tick) + 65536) >>> 17;
    s = (dr - dl) * longint'(dist_per_tick);
    wide = 128'(s) * 128'(signed'({1'b0, inv_track})) + (128'sd1 <<< 31);
    wide = wide >>> 32;
    dth = wide[63:0];
    p = longint'(dth) * longint'(RAD_TO_BIN) + 64'd32768;
    dbin = p[47:16];
    sincos_q30(pose_hdg - dbin, cs, sn);
    p = longint'(d) * longint'(cs) + (64'd1 << 29);
    pose_x += p[61:30];
    p = longint'(d) * longint'(sn) + (64'd1 << 29);
    pose_y += p[61:30];
    pose_hdg += dbin;
    half = pose_hdg >> 1;
    sincos_q30(half, cs, sn);
    w.pos_x = pose_x;
    w.pos_y = pose_y;
    w.heading = pose_hdg;
    w.quat_z = round_q14(sn);
    w.quat_w = round_q14(cs);
    w.lin_vel = per_second(d, t);
    w.ang_vel = per_second(dth, t);
    return w;
  endfunction

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected %0h, got %0h", name, exp_v, act_v);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    pose_word_t e;
    if (!rst_n) begin
      dist_per_tick <= DPT_RESET;
      inv_track     <= INV_RESET;
      prev_right = 0; prev_left = 0;
      pose_x = 0; pose_y = 0; pose_hdg = 0;
      pose_q.delete();
      fail_count = 0;
      pending   <= 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (reg_idx_t'(paddr[2]) == REG_DIST_PER_TICK) dist_per_tick <= pwdata[23:0];
        else inv_track <= pwdata[23:0];
      end
      if (in_valid && !in_stall)
        pose_q.push_back(advance_pose(in_right_count, in_left_count, in_elapsed_us));
      if (out_valid && !out_stall) begin
        if (pose_q.size() == 0) begin
          $error("result word with no expectation pending");
          fail_count++;
        end else begin
          e = pose_q.pop_front();
          check_field("pos_x", e.pos_x, out_pos_x);
          check_field("pos_y", e.pos_y, out_pos_y);
          check_field("heading", e.heading, out_heading);
          check_field("quat_z", {16'd0, e.quat_z}, {16'd0, out_quat_z});
          check_field("quat_w", {16'd0, e.quat_w}, {16'd0, out_quat_w});
          check_field("linear_velocity", e.lin_vel, out_linear_velocity);
          check_field("angular_velocity", e.ang_vel, out_angular_velocity);
        end
      end
      pending <= pose_q.size();
    end
  end

endmodule

// ----- tb/tb_diff_drive_odometry_unit.sv -----
// Stimulus, clocking and verdict for the odometry block testbench.
module tb_diff_drive_odometry_unit;
  import odo_pkg::*;

  localparam int IDLE_LIMIT = 5000;
  localparam int SETTLE     = 300;

  logic               clk, rst_n;
  logic               in_valid, in_stall;
  logic signed [31:0] in_right_count, in_left_count;
  logic [31:0]        in_elapsed_us;
  logic               out_valid, out_stall;
  logic signed [31:0] out_pos_x, out_pos_y;
  logic [31:0]        out_heading;
  logic signed [15:0] out_quat_z, out_quat_w;
  logic signed [31:0] out_linear_velocity, out_angular_velocity;
  logic               psel, penable, pwrite, pready;
  logic [2:0]         paddr;
  logic [31:0]        pwdata, prdata;

  int fail_count, pending;
  int cycle_cnt, idle_cnt, words_sent, cfg_writes;
  logic [31:0] right_pos, left_pos;

  diff_drive_odometry_unit uut (.*);

  odo_checker chk (
    .clk, .rst_n, .in_valid, .in_stall, .in_right_count, .in_left_count,
    .in_elapsed_us, .out_valid, .out_stall, .out_pos_x, .out_pos_y,
    .out_heading, .out_quat_z, .out_quat_w, .out_linear_velocity,
    .out_angular_velocity, .psel, .penable, .pwrite, .paddr, .pwdata,
    .pready, .fail_count, .pending);

  always begin
    clk = 1'b0; #5;
    clk = 1'b1; #5;
  end

  // Receiver: stall at random about 17 times in a hundred, with a clean
  // stretch of no stalls in one window of the cycle count since reset.
  always @(posedge clk) begin
    if (!rst_n) cycle_cnt <= 0;
    else cycle_cnt <= cycle_cnt + 1;
    if (!rst_n || (cycle_cnt > 20000 && cycle_cnt < 40000)) out_stall <= 1'b0;
    else out_stall <= ($urandom_range(99) < 17);
  end

  // Watchdog: end the run if nothing moves for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (psel && penable))
      idle_cnt <= 0;
    else
      idle_cnt <= idle_cnt + 1;
    if (idle_cnt >= IDLE_LIMIT) begin
      $display("timeout: no handshake for %0d cycles", IDLE_LIMIT);
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Present one word and hold it until accepted; possibly idle first if asked.
  task automatic send_word(input logic [31:0] rc, input logic [31:0] lc,
                           input logic [31:0] t, input bit may_idle);
    if (may_idle && $urandom_range(99) < 17) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_right_count <= rc;
    in_left_count  <= lc;
    in_elapsed_us  <= t;
    right_pos = rc;
    left_pos  = lc;
    do @(posedge clk); while (in_stall);
    words_sent++;
  endtask

  // Move each wheel by a delta from its last count.
  task automatic move(input int dr, input int dl, input logic [31:0] t,
                      input bit may_idle);
    send_word(right_pos + dr, left_pos + dl, t, may_idle);
  endtask

  // Drain, let the block settle, then do one APB write.
  task automatic write_reg(input reg_idx_t idx, input logic [23:0] val);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {8'd0, val};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    cfg_writes++;
  endtask

  function automatic logic [31:0] pick_time();
    int sel;
    sel = $urandom_range(9);
    if (sel == 0) return 32'd0;
    if (sel < 7) return $urandom_range(1000, 100000);
    if (sel < 9) return $urandom_range(1, 50);
    return $urandom;
  endfunction

  task automatic random_phase(input int n, input bit no_idle);
    int k;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(19);
      if (k == 0) send_word($urandom, $urandom, pick_time(), !no_idle);
      else if (k < 3) move($urandom_range(0, 200000) - 100000,
                           $urandom_range(0, 200000) - 100000, pick_time(), !no_idle);
      else move($urandom_range(0, 4000) - 2000, $urandom_range(0, 4000) - 2000,
                pick_time(), !no_idle);
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0; in_right_count = '0; in_left_count = '0; in_elapsed_us = '0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    words_sent = 0; cfg_writes = 0;
    right_pos = 0; left_pos = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed words at reset settings: still, zero time, extremes, wraps.
    move(0, 0, 32'd1000, 0);
    move(100, 100, 32'd0, 0);
    move(1000, 1000, 32'd10000, 0);
    move(500, -500, 32'd20000, 0);
    move(-800, 800, 32'd20000, 0);
    move(2000, 0, 32'd1, 0);
    move(0, -2000, 32'd1, 0);
    move(-3000, -3000, 32'hFFFF_FFFF, 0);
    send_word(32'h7FFF_FFFF, 32'h8000_0000, 32'd1, 0);
    send_word(32'h8000_0000, 32'h7FFF_FFFF, 32'd1, 0);
    send_word(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
    send_word(32'h0000_0000, 32'h0000_0000, 32'd0, 0);
    move(0, 0, 32'd0, 0);
    for (int i = 0; i < 8; i++) move(40000, -40000, 32'd5000, 0);

    // Extreme register settings, then random phases across several configs.
    write_reg(REG_DIST_PER_TICK, 24'hFF_FFFF);
    write_reg(REG_INV_TRACK, 24'hFF_FFFF);
    send_word(32'h7FFF_FFFF, 32'h8000_0001, 32'd1, 0);
    random_phase(200, 0);
    write_reg(REG_DIST_PER_TICK, 24'd1);
    write_reg(REG_INV_TRACK, 24'd1);
    random_phase(200, 0);
    write_reg(REG_DIST_PER_TICK, DPT_RESET);
    write_reg(REG_INV_TRACK, INV_RESET);
    random_phase(400, 1);
    random_phase(200, 0);
    write_reg(REG_DIST_PER_TICK, 24'($urandom_range(1, 24'hFF_FFFF)));
    write_reg(REG_INV_TRACK, 24'($urandom_range(1, 24'hFF_FFFF)));
    random_phase(200, 0);

    // Wait for every result, then a settle window.
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);

    $display("covered %0d input words over %0d register writes,", words_sent, cfg_writes);
    $display("including count wraps, zero elapsed time and extreme registers");
    if (fail_count == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/core/odo_pkg.sv
rtl/core/odo_mul.sv
rtl/core/odo_cordic.sv
rtl/core/odo_div.sv
rtl/core/diff_drive_odometry_unit.sv
tb/odo_checker.sv
tb/tb_diff_drive_odometry_unit.sv
